// ===== design/sfr_pkg.sv =====
// Shared types and codes of the sensor frame receiver.
package sfr_pkg;

    localparam int BYTE_W   = 8;
    localparam int LENGTH_W = 16;
    localparam int POS_W    = 17;
    localparam int STATUS_W = 3;
    localparam int VERDICT_W = 2;
    localparam int REG_INDEX_W = 1;

    // Register indexes of the configuration port
    localparam logic [REG_INDEX_W-1:0] REG_NULL_CHECKSUM = 1'd0;
    localparam logic [REG_INDEX_W-1:0] REG_ACK_COMMAND   = 1'd1;

    // Frame status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HEADER_SUM   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUTER_LENGTH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MSG_LENGTH   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM     = 3'd5;

    // Acknowledge verdict codes
    localparam logic [VERDICT_W-1:0] ACK_POSITIVE   = 2'd0;
    localparam logic [VERDICT_W-1:0] ACK_UNEXPECTED = 2'd1;
    localparam logic [VERDICT_W-1:0] ACK_NEGATIVE   = 2'd2;

    localparam logic [BYTE_W-1:0] CHECKSUM_BASE = 8'hAA;
    localparam logic [BYTE_W-1:0] ACK_OK_MASK   = 8'h01;

    typedef struct packed {
        logic [BYTE_W-1:0]    payload_byte;
        logic                 payload_valid;
        logic                 done_res;
        logic [STATUS_W-1:0]  frame_status;
        logic [BYTE_W-1:0]    frame_flags;
        logic [BYTE_W-1:0]    command;
        logic [LENGTH_W-1:0]  payload_count;
        logic                 command_match;
        logic [VERDICT_W-1:0] ack_verdict;
        logic [BYTE_W-1:0]    ack_status;
    } result_t;

endpackage

// ===== design/sfr_parser.sv =====
// Frame state, running sums and verdict logic for one byte per step.
module sfr_parser #(
    parameter int MAX_OUTER_LENGTH = 65535
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [sfr_pkg::BYTE_W-1:0] wire_byte,
    input  logic                       last,
    input  logic [sfr_pkg::BYTE_W-1:0] wanted_command,
    input  logic [sfr_pkg::BYTE_W-1:0] null_checksum_code,
    input  logic [sfr_pkg::BYTE_W-1:0] ack_command_code,
    output sfr_pkg::result_t           res
);
    import sfr_pkg::*;

    localparam logic [POS_W-1:0] POS_FLAGS      = 17'd0;
    localparam logic [POS_W-1:0] POS_LEN_LO     = 17'd1;
    localparam logic [POS_W-1:0] POS_LEN_HI     = 17'd2;
    localparam logic [POS_W-1:0] POS_HDR_SUM    = 17'd3;
    localparam logic [POS_W-1:0] POS_COMMAND    = 17'd4;
    localparam logic [POS_W-1:0] POS_MLEN_LO    = 17'd5;
    localparam logic [POS_W-1:0] POS_MLEN_HI    = 17'd6;
    localparam logic [POS_W-1:0] POS_PAYLOAD0   = 17'd7;
    localparam logic [POS_W-1:0] POS_PAYLOAD1   = 17'd8;
    localparam logic [POS_W-1:0] POS_MAX        = {POS_W{1'b1}};
    localparam logic [LENGTH_W-1:0] MIN_LENGTH  = 16'd4;
    localparam logic [LENGTH_W-1:0] HEADER_TAIL = 16'd3;
    localparam logic [POS_W:0] HEADER_BYTES     = 18'd4;
    localparam logic [LENGTH_W:0] MAX_LEN       = (LENGTH_W+1)'(MAX_OUTER_LENGTH);

    logic [POS_W-1:0]    pos_reg, pos_upd;
    logic [BYTE_W-1:0]   header_sum_reg, header_sum_upd;
    logic [BYTE_W-1:0]   message_sum_reg, message_sum_upd;
    logic [BYTE_W-1:0]   flags_reg, flags_upd;
    logic [LENGTH_W-1:0] outer_len_reg, outer_len_upd;
    logic [BYTE_W-1:0]   command_reg, command_upd;
    logic [LENGTH_W-1:0] len_field_reg, len_field_upd;
    logic [BYTE_W-1:0]   payload0_reg, payload0_upd;
    logic [BYTE_W-1:0]   payload1_reg, payload1_upd;
    logic                checksum_ok_reg, checksum_ok_upd;
    logic                header_ok_reg, header_ok_upd;

    logic [POS_W-1:0]    cks_pos;
    logic                len_min_ok;
    logic                len_max_bad;
    logic                msg_len_ok;
    logic                in_message;
    logic                in_payload;
    logic                len_too_long;
    logic [LENGTH_W-1:0] plen;
    logic [STATUS_W-1:0] status;

    always_comb
    begin
        cks_pos     = POS_W'(outer_len_reg) + POS_W'(HEADER_TAIL);
        len_min_ok  = outer_len_reg >= MIN_LENGTH;
        len_max_bad = {1'b0, outer_len_reg} > MAX_LEN;
        msg_len_ok  = len_min_ok && !len_max_bad &&
                      (len_field_reg == outer_len_reg - HEADER_TAIL);
        in_message  = (pos_reg >= POS_COMMAND) && (pos_reg < cks_pos);
        in_payload  = (pos_reg >= POS_PAYLOAD0) && (pos_reg < cks_pos);

        header_sum_upd  = header_sum_reg;
        message_sum_upd = message_sum_reg;
        flags_upd       = flags_reg;
        outer_len_upd   = outer_len_reg;
        command_upd     = command_reg;
        len_field_upd   = len_field_reg;
        payload0_upd    = payload0_reg;
        payload1_upd    = payload1_reg;
        checksum_ok_upd = checksum_ok_reg;
        header_ok_upd   = header_ok_reg;

        if (pos_reg == POS_FLAGS)
        begin
            flags_upd      = wire_byte;
            header_sum_upd = wire_byte;
        end
        if (pos_reg == POS_LEN_LO)
        begin
            outer_len_upd  = {8'd0, wire_byte};
            header_sum_upd = header_sum_reg + wire_byte;
        end
        if (pos_reg == POS_LEN_HI)
        begin
            outer_len_upd  = {wire_byte, outer_len_reg[BYTE_W-1:0]};
            header_sum_upd = header_sum_reg + wire_byte;
        end
        if (pos_reg == POS_HDR_SUM)
            header_ok_upd = (wire_byte == header_sum_reg);
        if (pos_reg == POS_COMMAND)
            command_upd = wire_byte;
        if (pos_reg == POS_MLEN_LO)
            len_field_upd = {8'd0, wire_byte};
        if (pos_reg == POS_MLEN_HI)
            len_field_upd = {wire_byte, len_field_reg[BYTE_W-1:0]};

        if (in_message)
            message_sum_upd = message_sum_reg + wire_byte;
        if (in_payload && (pos_reg == POS_PAYLOAD0))
            payload0_upd = wire_byte;
        if (in_payload && (pos_reg == POS_PAYLOAD1))
            payload1_upd = wire_byte;
        if (len_min_ok && (pos_reg == cks_pos))
            checksum_ok_upd = (wire_byte == CHECKSUM_BASE - message_sum_reg) ||
                              (wire_byte == null_checksum_code);

        // saturate the position so a long transfer stays past the message
        pos_upd = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);

        len_too_long = ({2'b00, outer_len_reg} + HEADER_BYTES > {1'b0, pos_upd}) ||
                       len_max_bad;
        plen = len_min_ok ? outer_len_reg - MIN_LENGTH : '0;

        priority if (pos_upd < POS_W'(HEADER_BYTES))
            status = ST_SHORT;
        else if (!header_ok_upd)
            status = ST_HEADER_SUM;
        else if (len_too_long)
            status = ST_OUTER_LENGTH;
        else if (!msg_len_ok)
            status = ST_MSG_LENGTH;
        else if (!checksum_ok_upd)
            status = ST_CHECKSUM;
        else
            status = ST_OK;

        res = '0;
        if (in_payload && header_ok_reg && msg_len_ok)
        begin
            res.payload_byte  = wire_byte;
            res.payload_valid = 1'b1;
        end
        if (last)
        begin
            res.done_res     = 1'b1;
            res.frame_status = status;
            res.ack_verdict  = ACK_UNEXPECTED;
            if ((status == ST_OK) || (status == ST_MSG_LENGTH) || (status == ST_CHECKSUM))
                res.frame_flags = flags_upd;
            if (status == ST_OK)
            begin
                res.command        = command_upd;
                res.payload_count  = plen;
                res.command_match  = (command_upd == wanted_command);
                if ((command_upd == ack_command_code) && (plen >= 16'd2) &&
                    (payload0_upd == wanted_command))
                begin
                    res.ack_status  = payload1_upd;
                    res.ack_verdict = ((payload1_upd & ACK_OK_MASK) != '0) ?
                                      ACK_POSITIVE : ACK_NEGATIVE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            header_sum_reg  <= '0;
            message_sum_reg <= '0;
            flags_reg       <= '0;
            outer_len_reg   <= '0;
            command_reg     <= '0;
            len_field_reg   <= '0;
            payload0_reg    <= '0;
            payload1_reg    <= '0;
            checksum_ok_reg <= 1'b0;
            header_ok_reg   <= 1'b0;
        end
        else if (step && last)
        begin
            // drop the frame, ready for the next transfer
            pos_reg         <= '0;
            header_sum_reg  <= '0;
            message_sum_reg <= '0;
            flags_reg       <= '0;
            outer_len_reg   <= '0;
            command_reg     <= '0;
            len_field_reg   <= '0;
            payload0_reg    <= '0;
            payload1_reg    <= '0;
            checksum_ok_reg <= 1'b0;
            header_ok_reg   <= 1'b0;
        end
        else if (step)
        begin
            pos_reg         <= pos_upd;
            header_sum_reg  <= header_sum_upd;
            message_sum_reg <= message_sum_upd;
            flags_reg       <= flags_upd;
            outer_len_reg   <= outer_len_upd;
            command_reg     <= command_upd;
            len_field_reg   <= len_field_upd;
            payload0_reg    <= payload0_upd;
            payload1_reg    <= payload1_upd;
            checksum_ok_reg <= checksum_ok_upd;
            header_ok_reg   <= header_ok_upd;
        end
    end

`ifndef SYNTHESIS
    a_payload_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        res.payload_valid |-> (pos_reg >= POS_PAYLOAD0) && header_ok_reg)
        else $error("payload byte streamed before the message payload");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last) |=> (pos_reg == '0) && !header_ok_reg && !checksum_ok_reg)
        else $error("frame state not cleared after final byte");

    a_bad_frame_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res.done_res && (res.frame_status != ST_OK)) |->
            (res.command == '0) && (res.ack_verdict == ACK_UNEXPECTED) &&
            (res.ack_status == '0))
        else $error("message fields reported on a failed frame");

    a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(pos_reg) && $stable(message_sum_reg))
        else $error("frame state moved without a request");
`endif

endmodule

// ===== design/sensor_frame_receiver.sv =====
// Top level of the sensor frame receiver: input stage, frame parser, result stage.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one byte of a USB transfer per
//   request, with last set on the final byte and wanted_command sampled
//   with that byte. Output channel (out_valid/out_ready) returns exactly one
//   result per input byte: a streamed payload byte when payload_valid is set,
//   and on the final byte done_res with the frame verdict fields.
//   Configuration writes (cfg_write_en, cfg_index, cfg_data) take effect at
//   the clock edge and must be made while no request is in flight.
// Timing:
//   A request enters an input register; the parser runs between that register
//   and the result register, which captures the result when the request advances.
//   One byte per cycle is sustained while out_ready stays high; the running
//   header and message sums update once per byte in the parser.
// Reset:
//   rst_n clears both stages, all frame state and both configuration
//   registers. When the receiver stalls, the result register holds, then the
//   input register fills and in_ready drops until out_ready returns.
module sensor_frame_receiver #(
    parameter int MAX_OUTER_LENGTH = 65535
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sfr_pkg::BYTE_W-1:0]        wire_byte,
    input  logic                              last,
    input  logic [sfr_pkg::BYTE_W-1:0]        wanted_command,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sfr_pkg::BYTE_W-1:0]        payload_byte,
    output logic                              payload_valid,
    output logic                              done_res,
    output logic [sfr_pkg::STATUS_W-1:0]      frame_status,
    output logic [sfr_pkg::BYTE_W-1:0]        frame_flags,
    output logic [sfr_pkg::BYTE_W-1:0]        command,
    output logic [sfr_pkg::LENGTH_W-1:0]      payload_count,
    output logic                              command_match,
    output logic [sfr_pkg::VERDICT_W-1:0]     ack_verdict,
    output logic [sfr_pkg::BYTE_W-1:0]        ack_status,
    input  logic                              cfg_write_en,
    input  logic [sfr_pkg::REG_INDEX_W-1:0]   cfg_index,
    input  logic [sfr_pkg::BYTE_W-1:0]        cfg_data
);
    import sfr_pkg::*;

    logic                in_valid_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic                last_reg;
    logic [BYTE_W-1:0]   expected_reg;
    logic                out_valid_reg;
    result_t             res_reg;
    result_t             res_next;
    logic [BYTE_W-1:0]   null_code_reg;
    logic [BYTE_W-1:0]   ack_code_reg;
    logic                advance;

    // advance the request into the result stage whenever that stage frees up
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg     <= wire_byte;
            last_reg     <= last;
            expected_reg <= wanted_command;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            null_code_reg <= '0;
            ack_code_reg  <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_NULL_CHECKSUM: null_code_reg <= cfg_data;
                REG_ACK_COMMAND:   ack_code_reg  <= cfg_data;
                default:           null_code_reg <= null_code_reg;
            endcase
        end
    end

    sfr_parser #(
        .MAX_OUTER_LENGTH (MAX_OUTER_LENGTH)
    ) u_parser (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (advance),
        .wire_byte          (byte_reg),
        .last               (last_reg),
        .wanted_command     (expected_reg),
        .null_checksum_code (null_code_reg),
        .ack_command_code   (ack_code_reg),
        .res                (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign payload_byte   = res_reg.payload_byte;
    assign payload_valid  = res_reg.payload_valid;
    assign done_res       = res_reg.done_res;
    assign frame_status   = res_reg.frame_status;
    assign frame_flags    = res_reg.frame_flags;
    assign command        = res_reg.command;
    assign payload_count  = res_reg.payload_count;
    assign command_match  = res_reg.command_match;
    assign ack_verdict    = res_reg.ack_verdict;
    assign ack_status     = res_reg.ack_status;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !advance)
        else $error("result overwritten while stalled");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg && $stable(byte_reg) && $stable(last_reg))
        else $error("pending request lost in input stage");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced request did not reach result stage");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench of the sensor frame receiver.
module tb;
    import sfr_pkg::*;

    localparam int MAX_LEN = 65535;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef struct packed {
        logic [BYTE_W-1:0] wire_byte;
        logic              last;
        logic [BYTE_W-1:0] wanted_command;
    } byte_req_t;

    typedef enum {
        FLAW_NONE,
        FLAW_HEADER_SUM,
        FLAW_LENGTH_FIELD,
        FLAW_CHECKSUM,
        FLAW_OUTER_LENGTH,
        FLAW_SMALL_OUTER
    } frame_flaw_t;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [BYTE_W-1:0] wire_byte = '0;
    logic last = 1'b0;
    logic [BYTE_W-1:0] wanted_command = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [BYTE_W-1:0] payload_byte;
    logic payload_valid;
    logic done_res;
    logic [STATUS_W-1:0] frame_status;
    logic [BYTE_W-1:0] frame_flags;
    logic [BYTE_W-1:0] command;
    logic [LENGTH_W-1:0] payload_count;
    logic command_match;
    logic [VERDICT_W-1:0] ack_verdict;
    logic [BYTE_W-1:0] ack_status;
    logic cfg_write_en = 1'b0;
    logic [REG_INDEX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0] cfg_data = '0;

    sensor_frame_receiver dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .wire_byte(wire_byte), .last(last), .wanted_command(wanted_command),
        .out_valid(out_valid), .out_ready(out_ready),
        .payload_byte(payload_byte), .payload_valid(payload_valid),
        .done_res(done_res), .frame_status(frame_status), .frame_flags(frame_flags),
        .command(command), .payload_count(payload_count),
        .command_match(command_match), .ack_verdict(ack_verdict),
        .ack_status(ack_status),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Parser copy: registers and per-transfer state
    logic [BYTE_W-1:0]   null_code = '0;
    logic [BYTE_W-1:0]   ack_code = '0;
    logic [POS_W-1:0]    rx_pos = '0;
    logic [BYTE_W-1:0]   hdr_sum = '0;
    logic [BYTE_W-1:0]   msg_sum = '0;
    logic [BYTE_W-1:0]   flags_q = '0;
    logic [LENGTH_W-1:0] outer_len = '0;
    logic [BYTE_W-1:0]   cmd_q = '0;
    logic [LENGTH_W-1:0] len_field = '0;
    logic [BYTE_W-1:0]   pay0 = '0;
    logic [BYTE_W-1:0]   pay1 = '0;
    logic                sum_ok = 1'b0;
    logic                hdr_good = 1'b0;

    byte_req_t   byte_queue[$];
    result_t     awaited_results[$];
    logic [7:0]  frame_bytes[$];
    byte_req_t   cur_req;
    result_t     head_result;
    int          queued_items = 0;
    int          mismatch_count = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    logic [5:0]  ready_cycle = '0;
    logic [1:0]  ready_mode = '0;

    function automatic void clear_frame();
        rx_pos = '0;
        hdr_sum = '0;
        msg_sum = '0;
        flags_q = '0;
        outer_len = '0;
        cmd_q = '0;
        len_field = '0;
        pay0 = '0;
        pay1 = '0;
        sum_ok = 1'b0;
        hdr_good = 1'b0;
    endfunction

    function automatic result_t parse_byte(input byte_req_t r);
        result_t res;
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] n;
        logic [POS_W-1:0] cks_pos;
        logic [POS_W-1:0] plen;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] want;
        logic len_ok;
        res = '0;
        b = r.wire_byte;
        p = rx_pos;
        cks_pos = 17'd3 + {1'b0, outer_len};
        len_ok = outer_len >= 16'd4 && {1'b0, outer_len} <= MAX_LEN &&
                 len_field == outer_len - 16'd3;
        case (p)
            17'd0:
            begin
                flags_q = b;
                hdr_sum = b;
            end
            17'd1:
            begin
                outer_len = {8'h00, b};
                hdr_sum = hdr_sum + b;
            end
            17'd2:
            begin
                outer_len[15:8] = b;
                hdr_sum = hdr_sum + b;
            end
            17'd3: hdr_good = (b == hdr_sum);
            17'd4: cmd_q = b;
            17'd5: len_field = {8'h00, b};
            17'd6: len_field[15:8] = b;
            default: ;
        endcase
        if (p >= 17'd4 && p < cks_pos)
            msg_sum = msg_sum + b;
        if (p >= 17'd7 && p < cks_pos)
        begin
            if (p == 17'd7)
                pay0 = b;
            else if (p == 17'd8)
                pay1 = b;
            if (hdr_good && len_ok)
            begin
                res.payload_byte = b;
                res.payload_valid = 1'b1;
            end
        end
        if (outer_len >= 16'd4 && p == cks_pos)
        begin
            want = CHECKSUM_BASE - msg_sum;
            sum_ok = (b == want) || (b == null_code);
        end
        if (rx_pos != POS_MAX)
            rx_pos = rx_pos + 1'b1;
        if (r.last)
        begin
            n = rx_pos;
            plen = (outer_len >= 16'd4) ? {1'b0, outer_len} - 17'd4 : '0;
            res.done_res = 1'b1;
            res.ack_verdict = ACK_UNEXPECTED;
            if (n < 17'd4)
                res.frame_status = ST_SHORT;
            else if (!hdr_good)
                res.frame_status = ST_HEADER_SUM;
            else if ({1'b0, outer_len} > n - 17'd4 || {1'b0, outer_len} > MAX_LEN)
                res.frame_status = ST_OUTER_LENGTH;
            else if (!len_ok)
                res.frame_status = ST_MSG_LENGTH;
            else if (!sum_ok)
                res.frame_status = ST_CHECKSUM;
            else
                res.frame_status = ST_OK;
            if (res.frame_status == ST_OK || res.frame_status == ST_MSG_LENGTH ||
                res.frame_status == ST_CHECKSUM)
                res.frame_flags = flags_q;
            if (res.frame_status == ST_OK)
            begin
                res.command = cmd_q;
                res.payload_count = plen[LENGTH_W-1:0];
                res.command_match = (cmd_q == r.wanted_command);
                // acknowledge: status byte follows the echoed command
                if (cmd_q == ack_code && plen >= 17'd2 && pay0 == r.wanted_command)
                begin
                    res.ack_status = pay1;
                    res.ack_verdict = ((pay1 & ACK_OK_MASK) != '0) ? ACK_POSITIVE
                                                                     : ACK_NEGATIVE;
                end
            end
            clear_frame();
        end
        return res;
    endfunction

    task automatic check_result(input result_t e);
        if (payload_byte !== e.payload_byte)
        begin
            $error("payload_byte: expected %0d, got %0d", e.payload_byte, payload_byte);
            mismatch_count++;
        end
        if (payload_valid !== e.payload_valid)
        begin
            $error("payload_valid: expected %0d, got %0d", e.payload_valid, payload_valid);
            mismatch_count++;
        end
        if (done_res !== e.done_res)
        begin
            $error("done_res: expected %0d, got %0d", e.done_res, done_res);
            mismatch_count++;
        end
        if (frame_status !== e.frame_status)
        begin
            $error("frame_status: expected %0d, got %0d", e.frame_status, frame_status);
            mismatch_count++;
        end
        if (frame_flags !== e.frame_flags)
        begin
            $error("frame_flags: expected %0d, got %0d", e.frame_flags, frame_flags);
            mismatch_count++;
        end
        if (command !== e.command)
        begin
            $error("command: expected %0d, got %0d", e.command, command);
            mismatch_count++;
        end
        if (payload_count !== e.payload_count)
        begin
            $error("payload_count: expected %0d, got %0d", e.payload_count,
                   payload_count);
            mismatch_count++;
        end
        if (command_match !== e.command_match)
        begin
            $error("command_match: expected %0d, got %0d", e.command_match, command_match);
            mismatch_count++;
        end
        if (ack_verdict !== e.ack_verdict)
        begin
            $error("ack_verdict: expected %0d, got %0d", e.ack_verdict, ack_verdict);
            mismatch_count++;
        end
        if (ack_status !== e.ack_status)
        begin
            $error("ack_status: expected %0d, got %0d", e.ack_status, ack_status);
            mismatch_count++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sender: bursts of requests separated by idle gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                awaited_results.push_back(parse_byte(cur_req));
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0 || byte_queue.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left <= gap_left - 1;
                end
                else
                begin
                    cur_req = byte_queue.pop_front();
                    in_valid <= 1'b1;
                    wire_byte <= cur_req.wire_byte;
                    last <= cur_req.last;
                    wanted_command <= cur_req.wanted_command;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 32);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver: stall pattern is redrawn each time ready_cycle wraps to zero
    always @(posedge clk)
    begin
        ready_cycle <= ready_cycle + 1'b1;
        if (ready_cycle == '0)
            ready_mode <= 2'($urandom_range(0, 3));
        case (ready_mode)
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= ($urandom_range(0, 3) != 0);
            2'd2: out_ready <= (ready_cycle[1:0] == 2'd0);
            default: out_ready <= (ready_cycle[3:0] >= 4'd10);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatch_count++;
            end
            else
            begin
                head_result = awaited_results.pop_front();
                check_result(head_result);
            end
        end
    end

    task automatic write_reg(input logic [REG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_NULL_CHECKSUM)
            null_code = val;
        else
            ack_code = val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (byte_queue.size() != 0 || in_valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Turn the assembled bytes into requests; wanted_command counts on the last one
    task automatic send_transfer(input logic [7:0] exp_cmd);
        byte_req_t r;
        foreach (frame_bytes[i])
        begin
            r.wire_byte = frame_bytes[i];
            r.last = (i == frame_bytes.size() - 1);
            r.wanted_command = r.last ? exp_cmd : 8'($urandom);
            byte_queue.push_back(r);
        end
        queued_items += frame_bytes.size();
        frame_bytes.delete();
    endtask

    task automatic add_frame(input frame_flaw_t flaw, input int plen, input int pad,
                             input logic [7:0] cmd, input logic [7:0] exp_cmd,
                             input bit use_null, input bit ack_form,
                             input logic [7:0] ack_byte);
        logic [15:0] olen;
        logic [15:0] lf;
        logic [7:0] hs;
        logic [7:0] ms;
        logic [7:0] b;
        logic [7:0] good;
        logic [7:0] ck;
        int keep;
        olen = (flaw == FLAW_SMALL_OUTER) ? 16'($urandom_range(0, 3)) : 16'(plen + 4);
        b = 8'($urandom);
        hs = b + olen[7:0] + olen[15:8];
        if (flaw == FLAW_HEADER_SUM)
            hs = hs + 8'($urandom_range(1, 255));
        frame_bytes.push_back(b);
        frame_bytes.push_back(olen[7:0]);
        frame_bytes.push_back(olen[15:8]);
        frame_bytes.push_back(hs);
        if (flaw == FLAW_SMALL_OUTER)
            repeat ($urandom_range(0, 6)) frame_bytes.push_back(8'($urandom));
        else
        begin
            lf = olen - 16'd3;
            if (flaw == FLAW_LENGTH_FIELD)
                lf = lf ^ 16'($urandom_range(1, 65535));
            ms = cmd + lf[7:0] + lf[15:8];
            frame_bytes.push_back(cmd);
            frame_bytes.push_back(lf[7:0]);
            frame_bytes.push_back(lf[15:8]);
            for (int i = 0; i < plen; i++)
            begin
                if (ack_form && i == 0)
                    b = exp_cmd;
                else if (ack_form && i == 1)
                    b = ack_byte;
                else
                    b = 8'($urandom);
                ms = ms + b;
                frame_bytes.push_back(b);
            end
            good = CHECKSUM_BASE - ms;
            ck = use_null ? null_code : good;
            if (flaw == FLAW_CHECKSUM)
                do ck = 8'($urandom); while (ck == good || ck == null_code);
            frame_bytes.push_back(ck);
            // cut the transfer short of the declared length
            if (flaw == FLAW_OUTER_LENGTH)
            begin
                keep = $urandom_range(4, frame_bytes.size() - 1);
                while (frame_bytes.size() > keep)
                    void'(frame_bytes.pop_back());
            end
        end
        if (flaw != FLAW_OUTER_LENGTH)
            repeat (pad) frame_bytes.push_back(8'($urandom));
        send_transfer(exp_cmd);
    endtask

    task automatic random_transfer();
        int kind;
        int plen;
        int pad;
        logic [7:0] cmd;
        logic [7:0] exp_cmd;
        frame_flaw_t flaw;
        kind = $urandom_range(0, 99);
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 12);
        pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        cmd = $urandom_range(0, 1) ? ack_code : 8'($urandom);
        exp_cmd = $urandom_range(0, 1) ? cmd : 8'($urandom);
        if (kind >= 90)
        begin
            repeat ($urandom_range(1, 20)) frame_bytes.push_back(8'($urandom));
            send_transfer(8'($urandom));
        end
        else
        begin
            if (kind < 60)
                flaw = FLAW_NONE;
            else if (kind < 66)
                flaw = FLAW_HEADER_SUM;
            else if (kind < 72)
                flaw = FLAW_LENGTH_FIELD;
            else if (kind < 80)
                flaw = FLAW_CHECKSUM;
            else if (kind < 86)
                flaw = FLAW_OUTER_LENGTH;
            else
                flaw = FLAW_SMALL_OUTER;
            add_frame(flaw, plen, pad, cmd, exp_cmd, $urandom_range(0, 4) == 0,
                      $urandom_range(0, 1) == 1, 8'($urandom));
        end
    endtask

    task automatic random_phase(input int goal);
        int start;
        start = queued_items;
        while (queued_items - start < goal)
            random_transfer();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short transfer, bad header sum, zero outer length, truncated frame
        frame_bytes = '{8'hFF};
        send_transfer(8'hFF);
        frame_bytes = '{8'h00, 8'hFF, 8'hFF, 8'h00};
        send_transfer(8'h00);
        frame_bytes = '{8'hFF, 8'h00, 8'h00, 8'hFF};
        send_transfer(8'h5A);
        frame_bytes = '{8'h80, 8'h02, 8'h00, 8'h82, 8'h11};
        send_transfer(8'hA5);
        // positive acknowledge with the reset command code
        add_frame(FLAW_NONE, 2, 0, 8'h00, 8'hFF, 1'b0, 1'b1, 8'h01);
        random_phase(350);
        wait_drained();

        write_reg(REG_NULL_CHECKSUM, 8'hFF);
        write_reg(REG_ACK_COMMAND, 8'hFF);
        random_phase(350);
        wait_drained();

        write_reg(REG_NULL_CHECKSUM, 8'($urandom));
        write_reg(REG_ACK_COMMAND, 8'($urandom));
        // long acknowledge frame with padding after the checksum
        add_frame(FLAW_NONE, 120, 6, ack_code, 8'($urandom), 1'b0, 1'b1, 8'($urandom));
        random_phase(400);
        wait_drained();

        write_reg(REG_NULL_CHECKSUM, 8'h00);
        write_reg(REG_ACK_COMMAND, 8'($urandom));
        random_phase(400);
        wait_drained();

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/sfr_pkg.sv
design/sfr_parser.sv
design/sensor_frame_receiver.sv
bench/tb.sv
